// ===== src/gasm_pkg.sv =====
`default_nettype none

package gasm_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned TIMEOUT_W = 11;
  localparam int unsigned TENTHS_W  = 9;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned HIGH_W    = 3;
  localparam int unsigned QUIET_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAS_THRESHOLD = 2'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 11'd360;
  localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET = 10'd15;

  localparam logic [HIGH_W-1:0] HIGH_MAX = 3'd5;

  // tenths = floor(mean * 349 / 1023), as a reciprocal product
  localparam int unsigned        TENTHS_MUL_W = 29;
  localparam logic [28:0]        TENTHS_MUL   = 29'd366310750;
  localparam int unsigned        TENTHS_SHIFT = 30;

  localparam logic [TENTHS_W-1:0] TENTHS_FLOOR = 9'd150;
  localparam logic [TENTHS_W-1:0] TENTHS_CEIL  = 9'd232;
  localparam logic [TENTHS_W-1:0] TENTHS_WARN  = 9'd228;

  typedef enum logic [LEVEL_W-1:0] {
    LEVEL_NORMAL = 2'd0,
    LEVEL_WARN   = 2'd1,
    LEVEL_LOW    = 2'd2
  } level_e;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] alarm_timeout;
    logic [SAMPLE_W-1:0]  gas_threshold;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/gasm_window.sv =====
`default_nettype none

module gasm_window #(
  parameter int unsigned TAPS  = 4,
  parameter int unsigned WIDTH = 10,
  localparam int unsigned SUM_W = WIDTH + $clog2(TAPS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] sample_i,
  output logic      [SUM_W-1:0] sum_o,
  output logic                  full_o
);

  localparam int unsigned SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned FILL_W = $clog2(TAPS + 1);
  localparam int unsigned EXT_W  = SUM_W + 1;

  logic [WIDTH-1:0]  ring_q [TAPS];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [EXT_W-1:0]  sum_ext;
  logic              full;

  assign full    = (fill_q == FILL_W'(TAPS));
  assign sum_ext = EXT_W'(sum_q) + EXT_W'(sample_i) - EXT_W'(ring_q[slot_q]);
  assign sum_d   = sum_ext[SUM_W-1:0];
  assign slot_d  = (slot_q == SLOT_W'(TAPS - 1)) ? '0 : slot_q + SLOT_W'(1);
  assign fill_d  = full ? fill_q : fill_q + FILL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (en_i) begin
      ring_q[slot_q] <= sample_i;
      slot_q         <= slot_d;
      fill_q         <= fill_d;
      sum_q          <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign full_o = full;

endmodule

`default_nettype wire

// ===== src/gasm_alarm.sv =====
`default_nettype none

module gasm_alarm (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire gasm_pkg::cfg_t                  cfg_i,
  input  wire logic                            silence_i,
  input  wire logic [gasm_pkg::SAMPLE_W-1:0]   gas_average_i,
  output logic                                 alarm_o
);

  logic                             flag_q, flag_d;
  logic [gasm_pkg::HIGH_W-1:0]      high_q, high_d;
  logic [gasm_pkg::QUIET_W-1:0]     quiet_q, quiet_d, quiet_inc;
  logic [gasm_pkg::QUIET_W-1:0]     timeout16;
  logic                             disarmed;

  assign disarmed  = cfg_i.alarm_timeout[gasm_pkg::TIMEOUT_W-1];
  assign timeout16 = {{(gasm_pkg::QUIET_W - gasm_pkg::TIMEOUT_W){disarmed}},
                      cfg_i.alarm_timeout};
  assign quiet_inc = quiet_q + gasm_pkg::QUIET_W'(1);

  always_comb begin
    flag_d  = flag_q;
    high_d  = high_q;
    quiet_d = quiet_q;
    if (silence_i) begin
      flag_d = 1'b0;
    end
    if (gas_average_i > cfg_i.gas_threshold) begin
      if (!disarmed) begin
        if (high_q == gasm_pkg::HIGH_MAX) begin
          flag_d = 1'b1;
        end else begin
          high_d = high_q + gasm_pkg::HIGH_W'(1);
        end
      end
      quiet_d = '0;
    end else begin
      quiet_d = quiet_inc;
      if (quiet_inc == timeout16) begin
        quiet_d = '0;
        high_d  = '0;
        flag_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= 1'b0;
      high_q  <= '0;
      quiet_q <= '0;
    end else if (en_i) begin
      flag_q  <= flag_d;
      high_q  <= high_d;
      quiet_q <= quiet_d;
    end
  end

  assign alarm_o = flag_d;

endmodule

`default_nettype wire

// ===== src/gas_alarm_supply_monitor_core.sv =====
// Gas alarm and supply monitor.
// Input channel: in_valid_i with gas_sample_i, supply_sample_i and silence_i;
// a beat is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with alarm_active_o, supply_level_o,
// gas_average_o and supply_tenths_o; a beat leaves when out_valid_o is high
// and out_stall_i is low. Every input beat gives exactly one output beat.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 alarm timeout,
// 1 gas threshold) and cfg_data_i; cfg_ready_o is always high. Write only
// while no beat is in flight.
// An input beat passes the input register, window update, average division
// and alarm/scale stage into the output register. Throughput is one beat
// per cycle while out_stall_i is low; the window and alarm state each update
// once per beat in their own stage.
// Reset clears all windows, counters, the alarm and the held supply
// readings, and loads timeout 360 and threshold 15.
// A stall on the output holds the output register; stages behind it fill and
// then in_stall_o rises, with no beat lost.
`default_nettype none

module gas_alarm_supply_monitor_core #(
  parameter int unsigned GAS_TAPS    = 4,
  parameter int unsigned SUPPLY_TAPS = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [gasm_pkg::SAMPLE_W-1:0]     gas_sample_i,
  input  wire logic [gasm_pkg::SAMPLE_W-1:0]     supply_sample_i,
  input  wire logic                              silence_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   alarm_active_o,
  output logic [gasm_pkg::LEVEL_W-1:0]           supply_level_o,
  output logic [gasm_pkg::SAMPLE_W-1:0]          gas_average_o,
  output logic [gasm_pkg::TENTHS_W-1:0]          supply_tenths_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gasm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [gasm_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned GAS_SUM_W    = gasm_pkg::SAMPLE_W + $clog2(GAS_TAPS);
  localparam int unsigned SUPPLY_SUM_W = gasm_pkg::SAMPLE_W + $clog2(SUPPLY_TAPS);
  localparam int unsigned RECIP_SHIFT  = 20;
  localparam int unsigned RECIP_W      = RECIP_SHIFT + 1;
  localparam int unsigned GAS_RECIP    = (2 ** RECIP_SHIFT + GAS_TAPS - 1) / GAS_TAPS;
  localparam int unsigned SUPPLY_RECIP =
      (2 ** RECIP_SHIFT + SUPPLY_TAPS - 1) / SUPPLY_TAPS;
  localparam int unsigned GAS_PROD_W    = GAS_SUM_W + RECIP_W;
  localparam int unsigned SUPPLY_PROD_W = SUPPLY_SUM_W + RECIP_W;
  localparam int unsigned TENTHS_PROD_W = gasm_pkg::SAMPLE_W + gasm_pkg::TENTHS_MUL_W;

  // configuration
  gasm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_timeout <= gasm_pkg::TIMEOUT_RESET;
      cfg_q.gas_threshold <= gasm_pkg::THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gasm_pkg::REG_ALARM_TIMEOUT: begin
          cfg_q.alarm_timeout <= cfg_data_i[gasm_pkg::TIMEOUT_W-1:0];
        end
        gasm_pkg::REG_GAS_THRESHOLD: begin
          cfg_q.gas_threshold <= cfg_data_i[gasm_pkg::SAMPLE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // pipeline handshake
  logic v1_q, v2_q, v3_q, vo_q;
  logic adv2, adv3, advo;
  logic rdy1, rdy2, rdy3;
  logic in_take;

  assign advo    = v3_q && (!vo_q || !out_stall_i);
  assign rdy3    = !v3_q || advo;
  assign adv3    = v2_q && rdy3;
  assign rdy2    = !v2_q || adv3;
  assign adv2    = v1_q && rdy2;
  assign rdy1    = !v1_q || adv2;
  assign in_take = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (advo) begin
        vo_q <= 1'b1;
      end else if (!out_stall_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  // input register
  logic [gasm_pkg::SAMPLE_W-1:0] gas1_q, supply1_q;
  logic                          silence1_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      gas1_q     <= gas_sample_i;
      supply1_q  <= supply_sample_i;
      silence1_q <= silence_i;
    end
  end

  // window update
  logic [GAS_SUM_W-1:0]    gas_sum;
  logic [SUPPLY_SUM_W-1:0] supply_sum;
  logic                    gas_full;
  logic                    supply_full;
  logic                    silence2_q;

  gasm_window #(
    .TAPS  (GAS_TAPS),
    .WIDTH (gasm_pkg::SAMPLE_W)
  ) u_gas_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv2),
    .sample_i (gas1_q),
    .sum_o    (gas_sum),
    .full_o   (gas_full)
  );

  gasm_window #(
    .TAPS  (SUPPLY_TAPS),
    .WIDTH (gasm_pkg::SAMPLE_W)
  ) u_supply_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv2),
    .sample_i (supply1_q),
    .sum_o    (supply_sum),
    .full_o   (supply_full)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      silence2_q <= silence1_q;
    end
  end

  // averages by reciprocal product
  logic [GAS_PROD_W-1:0]         gas_prod;
  logic [SUPPLY_PROD_W-1:0]      supply_prod;
  logic [gasm_pkg::SAMPLE_W-1:0] gas_avg3_q, mean3_q;
  logic                          silence3_q, full3_q;

  assign gas_prod    = GAS_PROD_W'(gas_sum) * GAS_PROD_W'(GAS_RECIP);
  assign supply_prod = SUPPLY_PROD_W'(supply_sum) * SUPPLY_PROD_W'(SUPPLY_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      gas_avg3_q <= gas_prod[RECIP_SHIFT +: gasm_pkg::SAMPLE_W];
      mean3_q    <= supply_prod[RECIP_SHIFT +: gasm_pkg::SAMPLE_W];
      silence3_q <= silence2_q;
      full3_q    <= supply_full;
    end
  end

  // alarm and supply scaling
  logic                          alarm_next;
  logic [TENTHS_PROD_W-1:0]      tenths_prod;
  logic [gasm_pkg::TENTHS_W-1:0] tenths;
  gasm_pkg::level_e              level;

  gasm_alarm u_alarm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advo),
    .cfg_i         (cfg_q),
    .silence_i     (silence3_q),
    .gas_average_i (gas_avg3_q),
    .alarm_o       (alarm_next)
  );

  assign tenths_prod = TENTHS_PROD_W'(mean3_q) * TENTHS_PROD_W'(gasm_pkg::TENTHS_MUL);
  assign tenths      = tenths_prod[gasm_pkg::TENTHS_SHIFT +: gasm_pkg::TENTHS_W];

  always_comb begin
    if (tenths > gasm_pkg::TENTHS_FLOOR && tenths < gasm_pkg::TENTHS_CEIL) begin
      level = (tenths < gasm_pkg::TENTHS_WARN) ? gasm_pkg::LEVEL_LOW : gasm_pkg::LEVEL_WARN;
    end else begin
      level = gasm_pkg::LEVEL_NORMAL;
    end
  end

  // output register
  logic                          alarm_q;
  logic [gasm_pkg::SAMPLE_W-1:0] gas_avg_q;
  logic [gasm_pkg::TENTHS_W-1:0] tenths_q;
  gasm_pkg::level_e              level_q;

  always_ff @(posedge clk_i) begin
    if (advo) begin
      alarm_q   <= alarm_next;
      gas_avg_q <= gas_avg3_q;
    end
  end

  // hold the supply reading at its reset value until the window first fills
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenths_q <= '0;
      level_q  <= gasm_pkg::LEVEL_NORMAL;
    end else if (advo && full3_q) begin
      tenths_q <= tenths;
      level_q  <= level;
    end
  end

  assign in_stall_o      = !rdy1;
  assign out_valid_o     = vo_q;
  assign alarm_active_o  = alarm_q;
  assign gas_average_o   = gas_avg_q;
  assign supply_tenths_o = tenths_q;
  assign supply_level_o  = level_q;

  logic unused_gas_full;
  assign unused_gas_full = gas_full;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  import gasm_pkg::*;

  localparam int GAS_TAPS    = 4;
  localparam int SUPPLY_TAPS = 10;
  localparam int SCALE_NUM   = 3490;
  localparam int SCALE_DEN   = 1023;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 240;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] gas;
    logic [SAMPLE_W-1:0] supply;
    logic                silence;
  } sample_t;

  typedef struct packed {
    logic                alarm;
    level_e              level;
    logic [SAMPLE_W-1:0] gas_avg;
    logic [TENTHS_W-1:0] tenths;
  } reading_t;

  typedef struct packed {
    sample_t  stim;
    logic     typed;
    reading_t want;
  } row_t;

  localparam row_t DIRECTED [24] = '{
    '{'{10'd1023, 10'd1023, 1'b0}, 1'b1, '{1'b0, LEVEL_NORMAL, 10'd255, 9'd0}},
    '{'{10'd1023, 10'd1023, 1'b0}, 1'b1, '{1'b0, LEVEL_NORMAL, 10'd511, 9'd0}},
    '{'{10'd1023, 10'd1023, 1'b0}, 1'b1, '{1'b0, LEVEL_NORMAL, 10'd767, 9'd0}},
    '{'{10'd1023, 10'd1023, 1'b0}, 1'b1, '{1'b0, LEVEL_NORMAL, 10'd1023, 9'd0}},
    '{'{10'd1023, 10'd1023, 1'b0}, 1'b0, '0},
    '{'{10'd1023, 10'd1023, 1'b0}, 1'b1, '{1'b1, LEVEL_NORMAL, 10'd1023, 9'd0}},
    '{'{10'd1023, 10'd1023, 1'b1}, 1'b1, '{1'b1, LEVEL_NORMAL, 10'd1023, 9'd0}},
    '{'{10'd0,    10'd1023, 1'b0}, 1'b0, '0},
    '{'{10'd0,    10'd1023, 1'b0}, 1'b0, '0},
    '{'{10'd0,    10'd1023, 1'b0}, 1'b1, '{1'b1, LEVEL_NORMAL, 10'd255, 9'd349}},
    '{'{10'd0,    10'd0,    1'b1}, 1'b0, '0},
    '{'{10'h2AA,  10'd669,  1'b0}, 1'b0, '0},
    '{'{10'h155,  10'd669,  1'b0}, 1'b0, '0},
    '{'{10'h2AA,  10'd669,  1'b0}, 1'b0, '0},
    '{'{10'h155,  10'd669,  1'b0}, 1'b0, '0},
    '{'{10'h2AA,  10'd669,  1'b0}, 1'b0, '0},
    '{'{10'h155,  10'd669,  1'b0}, 1'b0, '0},
    '{'{10'd0,    10'd669,  1'b0}, 1'b0, '0},
    '{'{10'd0,    10'd669,  1'b0}, 1'b0, '0},
    '{'{10'd0,    10'd669,  1'b0}, 1'b0, '0},
    '{'{10'd0,    10'd669,  1'b1}, 1'b1, '{1'b0, LEVEL_WARN, 10'd0, 9'd228}},
    '{'{10'd1023, 10'd0,    1'b1}, 1'b0, '0},
    '{'{10'd512,  10'd512,  1'b0}, 1'b0, '0},
    '{'{10'd1,    10'd1,    1'b0}, 1'b0, '0}
  };

  localparam cfg_t SETTING_STEPS [7] = '{
    '{11'd600, 10'd0},
    '{11'd1,   10'd40},
    '{11'd3,   10'd300},
    '{11'h7FF, 10'd15},
    '{11'h7FE, 10'd100},
    '{11'd20,  10'd1023},
    '{11'd8,   10'd600}
  };

  localparam int SUPPLY_EDGES [8] = '{0, 440, 443, 668, 669, 680, 681, 1023};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [SAMPLE_W-1:0]  gas_sample_i = '0;
  logic [SAMPLE_W-1:0]  supply_sample_i = '0;
  logic                 silence_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 alarm_active_o;
  logic [LEVEL_W-1:0]   supply_level_o;
  logic [SAMPLE_W-1:0]  gas_average_o;
  logic [TENTHS_W-1:0]  supply_tenths_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  gas_alarm_supply_monitor_core #(
    .GAS_TAPS   (GAS_TAPS),
    .SUPPLY_TAPS(SUPPLY_TAPS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .gas_sample_i   (gas_sample_i),
    .supply_sample_i(supply_sample_i),
    .silence_i      (silence_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alarm_active_o (alarm_active_o),
    .supply_level_o (supply_level_o),
    .gas_average_o  (gas_average_o),
    .supply_tenths_o(supply_tenths_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [TIMEOUT_W-1:0] timeout_cfg = TIMEOUT_RESET;
  logic [SAMPLE_W-1:0]  threshold_cfg = THRESHOLD_RESET;
  logic [SAMPLE_W-1:0]  gas_hist [GAS_TAPS] = '{default: '0};
  logic [SAMPLE_W-1:0]  supply_hist [SUPPLY_TAPS] = '{default: '0};
  int                   gas_pos = 0;
  int                   supply_pos = 0;
  int                   supply_seen = 0;
  level_e               level_now = LEVEL_NORMAL;
  logic [TENTHS_W-1:0]  tenths_now = '0;
  logic [HIGH_W-1:0]    high_count = '0;
  logic [QUIET_W-1:0]   quiet_count = '0;
  logic                 alarm_on = 1'b0;

  reading_t readings_due [$];
  bit       idle_off = 1'b0;
  int       stall_left = 0;
  int       mismatches = 0;
  int       samples_sent = 0;
  int       readings_seen = 0;
  int       alarm_readings = 0;
  int       warn_readings = 0;
  int       low_readings = 0;
  int       reg_writes = 0;
  int       cycle_count = 0;

  function automatic reading_t next_reading(sample_t s);
    reading_t             r;
    int                   sum;
    int                   tenths;
    logic [QUIET_W-1:0]   clear_at;
    if (s.silence) alarm_on = 1'b0;

    gas_hist[gas_pos] = s.gas;
    gas_pos = (gas_pos + 1) % GAS_TAPS;
    sum = 0;
    foreach (gas_hist[i]) sum += gas_hist[i];
    r.gas_avg = SAMPLE_W'(sum / GAS_TAPS);

    supply_hist[supply_pos] = s.supply;
    supply_pos = (supply_pos + 1) % SUPPLY_TAPS;
    if (supply_seen < SUPPLY_TAPS) supply_seen++;
    if (supply_seen == SUPPLY_TAPS) begin
      sum = 0;
      foreach (supply_hist[i]) sum += supply_hist[i];
      tenths = (sum / SUPPLY_TAPS) * SCALE_NUM / SCALE_DEN / 10;
      tenths_now = TENTHS_W'(tenths);
      if (tenths < int'(TENTHS_CEIL) && tenths > int'(TENTHS_FLOOR))
        level_now = (tenths < int'(TENTHS_WARN)) ? LEVEL_LOW : LEVEL_WARN;
      else
        level_now = LEVEL_NORMAL;
    end

    if (r.gas_avg > threshold_cfg) begin
      if (!timeout_cfg[TIMEOUT_W-1]) begin
        if (high_count == HIGH_MAX) alarm_on = 1'b1;
        else high_count++;
      end
      quiet_count = '0;
    end else begin
      quiet_count++;
      clear_at = {{(QUIET_W-TIMEOUT_W){timeout_cfg[TIMEOUT_W-1]}}, timeout_cfg};
      if (quiet_count == clear_at) begin
        quiet_count = '0;
        high_count = '0;
        alarm_on = 1'b0;
      end
    end

    r.alarm = alarm_on;
    r.level = level_now;
    r.tenths = tenths_now;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < 10) $display("mismatch at reading %0d: %s", readings_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
               readings_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (readings_due.size() == 0) begin
          flag_mismatch("output beat with nothing expected");
        end else begin
          want = readings_due.pop_front();
          if (alarm_active_o !== want.alarm)
            flag_mismatch($sformatf("alarm_active expected %0d, got %0d",
                                    want.alarm, alarm_active_o));
          if (supply_level_o !== want.level)
            flag_mismatch($sformatf("supply_level expected %0d, got %0d",
                                    want.level, supply_level_o));
          if (gas_average_o !== want.gas_avg)
            flag_mismatch($sformatf("gas_average expected %0d, got %0d",
                                    want.gas_avg, gas_average_o));
          if (supply_tenths_o !== want.tenths)
            flag_mismatch($sformatf("supply_tenths expected %0d, got %0d",
                                    want.tenths, supply_tenths_o));
        end
        readings_seen++;
        if (alarm_active_o === 1'b1) alarm_readings++;
        if (supply_level_o === LEVEL_WARN) warn_readings++;
        if (supply_level_o === LEVEL_LOW) low_readings++;
        stall_left = idle_off ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  task automatic send_sample(sample_t s);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    gas_sample_i <= s.gas;
    supply_sample_i <= s.supply;
    silence_i <= s.silence;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    readings_due.push_back(next_reading(s));
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ALARM_TIMEOUT: timeout_cfg = data;
      REG_GAS_THRESHOLD: threshold_cfg = data[SAMPLE_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_settings(logic [TIMEOUT_W-1:0] tmo, logic [SAMPLE_W-1:0] thr);
    logic [CFG_W-1:0] thr_word;
    wait_idle();
    thr_word = CFG_W'(thr);
    thr_word[CFG_W-1] = ($urandom_range(0, 1) == 1);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_ALARM_TIMEOUT, tmo);
      write_reg(REG_GAS_THRESHOLD, thr_word);
    end else begin
      write_reg(REG_GAS_THRESHOLD, thr_word);
      write_reg(REG_ALARM_TIMEOUT, tmo);
    end
    write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
              CFG_W'($urandom_range(0, 2047)));
    cfg_valid_i <= 1'b0;
  endtask

  // random runs above or below the threshold, runs below at times sized around the timeout
  task automatic run_phase(int budget);
    int      sent;
    int      len;
    int      tmo;
    int      steady_supply;
    bit      rising;
    sample_t s;
    sent = 0;
    steady_supply = -1;
    tmo = int'($signed(timeout_cfg));
    while (sent < budget) begin
      idle_off = ($urandom_range(0, 3) == 0);
      rising = (threshold_cfg != '1) && ($urandom_range(0, 1) == 1);
      if (rising)
        len = $urandom_range(1, 10);
      else if (tmo > 0 && $urandom_range(0, 1) == 1)
        len = $urandom_range(tmo > 2 ? tmo - 2 : 1, tmo + 3);
      else
        len = $urandom_range(1, 10);
      if (len > budget - sent) len = budget - sent;
      if ($urandom_range(0, 3) == 0)
        steady_supply = ($urandom_range(0, 1) == 1) ? SUPPLY_EDGES[$urandom_range(0, 7)] : -1;
      repeat (len) begin
        if ($urandom_range(0, 7) == 0)
          s.gas = SAMPLE_W'($urandom_range(0, 1023));
        else if (rising)
          s.gas = SAMPLE_W'($urandom_range(int'(threshold_cfg) + 1, 1023));
        else
          s.gas = SAMPLE_W'($urandom_range(0, int'(threshold_cfg)));
        s.supply = (steady_supply < 0) ? SAMPLE_W'($urandom_range(0, 1023))
                                       : SAMPLE_W'(steady_supply);
        s.silence = ($urandom_range(0, 19) == 0);
        send_sample(s);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_sample(DIRECTED[i].stim);
      if (DIRECTED[i].typed) begin
        void'(readings_due.pop_back());
        readings_due.push_back(DIRECTED[i].want);
      end
    end

    foreach (SETTING_STEPS[i]) begin
      apply_settings(SETTING_STEPS[i].alarm_timeout, SETTING_STEPS[i].gas_threshold);
      run_phase(PHASE_ITEMS);
    end
    apply_settings(TIMEOUT_W'($urandom_range(0, 62) - 2), SAMPLE_W'($urandom_range(0, 1023)));
    run_phase(PHASE_ITEMS);

    wait_idle();

    $display("%0d samples in, %0d readings checked, %0d register writes",
             samples_sent, readings_seen, reg_writes);
    $display("readings with alarm set %0d, warning band %0d, low band %0d",
             alarm_readings, warn_readings, low_readings);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
